FILE: rtl/lgs_pkg.sv
// Shared constants, codes and control types of the lidar gap steering block.
package lgs_pkg;

	localparam int NUM_BEAMS    = 1080;
	localparam int BUBBLE_BELOW = 3;
	localparam int BUBBLE_ABOVE = 2;

	localparam int ADDR_W  = $clog2(NUM_BEAMS);
	localparam int CNT_W   = $clog2(NUM_BEAMS + 1);
	localparam int CMP_W   = ((ADDR_W > 11) ? ADDR_W : 11) + 2;

	localparam int RANGE_W = 17;
	localparam int IDX_W   = 11;
	localparam int STEP_W  = 13;
	localparam int STEER_W = 25;
	localparam int SPEED_W = 9;
	localparam int CFG_W   = 17;
	localparam int REG_W   = 3;

	localparam int PROD_W  = CMP_W + 1 + STEP_W + 1;

	localparam logic [ADDR_W-1:0] LAST_BEAM = ADDR_W'(NUM_BEAMS - 1);

	localparam int STEER_MAX = 16777215;
	localparam int STEER_MIN = -16777216;
	localparam int SPEED_FAST_LIMIT = 50000;
	localparam int SPEED_MID_LIMIT  = 400000;

	localparam logic [SPEED_W-1:0] SPEED_FAST = SPEED_W'(400);
	localparam logic [SPEED_W-1:0] SPEED_MID  = SPEED_W'(100);
	localparam logic [SPEED_W-1:0] SPEED_SLOW = SPEED_W'(50);

	typedef enum logic [REG_W-1:0] {
		REG_GAP_THRESHOLD = 3'd0,
		REG_WINDOW_LOW    = 3'd1,
		REG_WINDOW_HIGH   = 3'd2,
		REG_CENTER_INDEX  = 3'd3,
		REG_ANGLE_STEP    = 3'd4,
		REG_NEAREST_START = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIN,
		ST_GAP,
		ST_DRAIN,
		ST_MID,
		ST_MUL,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic vld;
		logic gap;
		logic init;
	} scan_ctl_t;

	typedef struct packed {
		logic mid;
		logic mul;
		logic fin;
	} steer_ctl_t;

endpackage

FILE: rtl/lgs_store.sv
// Beam range store: one write port, one registered read port.
module lgs_store import lgs_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [RANGE_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [RANGE_W-1:0] rdata
);

	logic [RANGE_W-1:0] mem [NUM_BEAMS];
	logic [RANGE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lgs_scan.sv
// Scan unit: nearest-sample search and longest free run, one beam per cycle.
module lgs_scan import lgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  logic [ADDR_W-1:0]  idx,
	input  logic [RANGE_W-1:0] data,
	input  logic [RANGE_W-1:0] gap_threshold_mm,
	input  logic [IDX_W-1:0]   window_low,
	input  logic [IDX_W-1:0]   window_high,
	input  logic [RANGE_W-1:0] nearest_start_mm,
	output logic               found,
	output logic [ADDR_W-1:0]  best_start,
	output logic [CNT_W-1:0]   best_len
);

	logic [RANGE_W-1:0] nearest_value_q;
	logic [ADDR_W-1:0]  nearest_index_q;
	logic               nearest_found_q;
	logic [CNT_W-1:0]   run_len_q;
	logic [ADDR_W-1:0]  run_start_q;
	logic [CNT_W-1:0]   best_len_q;
	logic [ADDR_W-1:0]  best_start_q;
	logic               found_q;

	logic [CMP_W-1:0] x_c, wl_c, wh_c, ni_c;
	logic             in_min_win, in_win, in_bubble, is_free, is_nearer;
	logic [CNT_W-1:0] new_len;
	logic [ADDR_W-1:0] new_start;

	always_comb begin
		x_c  = CMP_W'(idx);
		wl_c = CMP_W'(window_low);
		wh_c = CMP_W'(window_high);
		ni_c = CMP_W'(nearest_index_q);
		in_min_win = (x_c >= wl_c) && (x_c < wh_c);
		in_win     = (x_c >= wl_c) && (x_c <= wh_c);
		in_bubble  = nearest_found_q && (x_c + CMP_W'(BUBBLE_BELOW) >= ni_c)
			&& (x_c <= ni_c + CMP_W'(BUBBLE_ABOVE));
		is_free    = in_win && !in_bubble && (data > gap_threshold_mm);
		is_nearer  = in_min_win && (data < nearest_value_q);
		new_len    = run_len_q + CNT_W'(1);
		new_start  = (run_len_q == '0) ? idx : run_start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_value_q <= '0;
			nearest_index_q <= '0;
			nearest_found_q <= 1'b0;
			run_len_q       <= '0;
			run_start_q     <= '0;
			best_len_q      <= CNT_W'(1);
			best_start_q    <= '0;
			found_q         <= 1'b0;
		end else if (ctl.init) begin
			nearest_value_q <= nearest_start_mm;
			nearest_index_q <= '0;
			nearest_found_q <= 1'b0;
			run_len_q       <= '0;
			run_start_q     <= '0;
			best_len_q      <= CNT_W'(1);
			best_start_q    <= '0;
			found_q         <= 1'b0;
		end else if (ctl.vld && !ctl.gap) begin
			if (is_nearer) begin
				nearest_value_q <= data;
				nearest_index_q <= idx;
				nearest_found_q <= 1'b1;
			end
		end else if (ctl.vld && ctl.gap) begin
			if (is_free) begin
				run_len_q   <= new_len;
				run_start_q <= new_start;
				if (new_len > best_len_q) begin
					best_len_q   <= new_len;
					best_start_q <= new_start;
					found_q      <= 1'b1;
				end
			end else begin
				run_len_q <= '0;
			end
		end
	end

	assign found      = found_q;
	assign best_start = best_start_q;
	assign best_len   = best_len_q;

endmodule

FILE: rtl/lgs_steer.sv
// Steering unit: gap middle, angle multiply, saturation and speed choice.
module lgs_steer import lgs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  steer_ctl_t                ctl,
	input  logic                      found,
	input  logic [ADDR_W-1:0]         best_start,
	input  logic [CNT_W-1:0]          best_len,
	input  logic [IDX_W-1:0]          center_index,
	input  logic [STEP_W-1:0]         angle_step_urad,
	output logic                      done,
	output logic [IDX_W-1:0]          middle_beam,
	output logic                      gap_found,
	output logic [IDX_W-1:0]          gap_length,
	output logic signed [STEER_W-1:0] steering_urad,
	output logic [SPEED_W-1:0]        speed_cm_per_s
);

	logic [CMP_W-1:0]         middle_q;
	logic                     found_q;
	logic [CNT_W-1:0]         len_q;
	logic signed [PROD_W-1:0] product_q;

	logic                      done_q;
	logic [IDX_W-1:0]          middle_beam_q;
	logic                      gap_found_q;
	logic [IDX_W-1:0]          gap_length_q;
	logic signed [STEER_W-1:0] steering_q;
	logic [SPEED_W-1:0]        speed_q;

	logic [CMP_W:0]           mid_sum;
	logic signed [CMP_W:0]    diff;
	logic signed [PROD_W-1:0] product;
	logic signed [STEER_W-1:0] steer_sat;
	logic [SPEED_W-1:0]       speed;

	always_comb begin
		mid_sum = (CMP_W + 1)'(best_start) + (CMP_W + 1)'(best_start)
			+ (CMP_W + 1)'(best_len) - (CMP_W + 1)'(1);
		diff    = $signed({1'b0, middle_q}) - $signed((CMP_W + 1)'(center_index));
		product = PROD_W'(diff) * $signed({1'b0, angle_step_urad});
		if (product_q > PROD_W'(STEER_MAX)) begin
			steer_sat = STEER_W'(STEER_MAX);
		end else if (product_q < PROD_W'(STEER_MIN)) begin
			steer_sat = STEER_W'(STEER_MIN);
		end else begin
			steer_sat = STEER_W'(product_q);
		end
		if (steer_sat <= STEER_W'(SPEED_FAST_LIMIT)) begin
			speed = SPEED_FAST;
		end else if (steer_sat <= STEER_W'(SPEED_MID_LIMIT)) begin
			speed = SPEED_MID;
		end else begin
			speed = SPEED_SLOW;
		end
	end

	// middle, found and length are taken once the scan has settled
	always_ff @(posedge clk) begin
		if (ctl.mid) begin
			found_q  <= found;
			len_q    <= best_len;
			middle_q <= found ? mid_sum[CMP_W:1] : CMP_W'(center_index);
		end
		if (ctl.mul) begin
			product_q <= product;
		end
		if (ctl.fin) begin
			middle_beam_q <= middle_q[IDX_W-1:0];
			gap_found_q   <= found_q;
			gap_length_q  <= found_q ? len_q[IDX_W-1:0] : '0;
			steering_q    <= steer_sat;
			speed_q       <= speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.fin;
		end
	end

	assign done           = done_q;
	assign middle_beam    = middle_beam_q;
	assign gap_found      = gap_found_q;
	assign gap_length     = gap_length_q;
	assign steering_urad  = steering_q;
	assign speed_cm_per_s = speed_q;

endmodule

FILE: rtl/lidar_gap_steering.sv
// Top level of the lidar gap steering block: sequencer, registers and units.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start, busy         | range_mm
//  result   | done (one cycle)    | middle_beam, gap_found, gap_length,
//           |                     | steering_urad, speed_cm_per_s
//  config   | cfg_write           | cfg_index, cfg_data
//
// A beat that is not the last of a scan is stored and busy stays low. The
// last beat of a scan starts two sweeps through the store, one beam read per
// cycle on its single read port: nearest-sample search, then gap search, then
// the drain, middle, multiply and output steps. That beat holds busy high
// until the output step ends, and done pulses in the cycle busy falls.
// Reset clears the sequencer, the load count and the registers to their
// defaults; the store holds garbage until a full scan has been written.
// The receiver cannot stall: a result is shown for exactly one cycle.
module lidar_gap_steering import lgs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [RANGE_W-1:0]        range_mm,
	input  logic                      cfg_write,
	input  logic [REG_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output logic                      done,
	output logic [IDX_W-1:0]          middle_beam,
	output logic                      gap_found,
	output logic [IDX_W-1:0]          gap_length,
	output logic signed [STEER_W-1:0] steering_urad,
	output logic [SPEED_W-1:0]        speed_cm_per_s
);

	// configuration registers
	logic [RANGE_W-1:0] gap_threshold_q;
	logic [IDX_W-1:0]   window_low_q;
	logic [IDX_W-1:0]   window_high_q;
	logic [IDX_W-1:0]   center_index_q;
	logic [STEP_W-1:0]  angle_step_q;
	logic [RANGE_W-1:0] nearest_start_q;

	// sequencer
	seq_state_t        state_q, state_d;
	logic [ADDR_W-1:0] load_q;
	logic [ADDR_W-1:0] addr_q;
	logic              accept, last_beat;
	logic              rd_en, rd_gap;
	steer_ctl_t        steer_ctl;
	scan_ctl_t         scan_ctl;

	// read pipeline
	logic              rd_vld_s1;
	logic              rd_gap_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [RANGE_W-1:0] rd_data;

	// scan results
	logic              found;
	logic [ADDR_W-1:0] best_start;
	logic [CNT_W-1:0]  best_len;

	assign accept    = start && !busy;
	assign last_beat = accept && (load_q == LAST_BEAM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= RANGE_W'(1000);
			window_low_q    <= IDX_W'(270);
			window_high_q   <= IDX_W'(810);
			center_index_q  <= IDX_W'(540);
			angle_step_q    <= STEP_W'(5760);
			nearest_start_q <= RANGE_W'(100000);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAP_THRESHOLD: gap_threshold_q <= cfg_data;
				REG_WINDOW_LOW:    window_low_q    <= cfg_data[IDX_W-1:0];
				REG_WINDOW_HIGH:   window_high_q   <= cfg_data[IDX_W-1:0];
				REG_CENTER_INDEX:  center_index_q  <= cfg_data[IDX_W-1:0];
				REG_ANGLE_STEP:    angle_step_q    <= cfg_data[STEP_W-1:0];
				REG_NEAREST_START: nearest_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (last_beat) state_d = ST_MIN;
			ST_MIN:   if (addr_q == LAST_BEAM) state_d = ST_GAP;
			ST_GAP:   if (addr_q == LAST_BEAM) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_MID;
			ST_MID:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy      = 1'b1;
		rd_en     = 1'b0;
		rd_gap    = 1'b0;
		steer_ctl = '0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_MIN:  rd_en = 1'b1;
			ST_GAP: begin
				rd_en  = 1'b1;
				rd_gap = 1'b1;
			end
			ST_DRAIN: ;
			ST_MID:  steer_ctl.mid = 1'b1;
			ST_MUL:  steer_ctl.mul = 1'b1;
			ST_OUT:  steer_ctl.fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			load_q    <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_gap_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			rd_gap_s1 <= rd_gap;
			// advance the load count; wrap on the last beam of a scan
			if (accept) begin
				load_q <= last_beat ? '0 : load_q + ADDR_W'(1);
			end
			// sweep address: both passes run from beam zero to the last beam
			if (rd_en) begin
				addr_q <= (addr_q == LAST_BEAM) ? '0 : addr_q + ADDR_W'(1);
			end
		end
	end

	// index of the beam whose data leaves the store this cycle
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
	end

	always_comb begin
		scan_ctl.vld  = rd_vld_s1;
		scan_ctl.gap  = rd_gap_s1;
		scan_ctl.init = last_beat;
	end

	lgs_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (load_q),
		.wdata (range_mm),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	lgs_scan u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (scan_ctl),
		.idx              (rd_idx_s1),
		.data             (rd_data),
		.gap_threshold_mm (gap_threshold_q),
		.window_low       (window_low_q),
		.window_high      (window_high_q),
		.nearest_start_mm (nearest_start_q),
		.found            (found),
		.best_start       (best_start),
		.best_len         (best_len)
	);

	lgs_steer u_steer (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (steer_ctl),
		.found           (found),
		.best_start      (best_start),
		.best_len        (best_len),
		.center_index    (center_index_q),
		.angle_step_urad (angle_step_q),
		.done            (done),
		.middle_beam     (middle_beam),
		.gap_found       (gap_found),
		.gap_length      (gap_length),
		.steering_urad   (steering_urad),
		.speed_cm_per_s  (speed_cm_per_s)
	);

	// the result beat follows the output step, and busy has dropped by then
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> (done && !busy))
		else $error("result beat missing after output step");

	// a result beat only ever follows the output step
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_OUT))
		else $error("result beat without output step");

	// no gap means zero length
	a_no_gap_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !gap_found) |-> (gap_length == '0))
		else $error("gap length set without a gap");

	// the scan starts only on the last beat of a scan
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && ($past(load_q) == LAST_BEAM)))
		else $error("scan started before the store was full");

endmodule
